[hdl/oscmp_pkg.sv]
// Shared constants and types for the OSC message parser.
package oscmp_pkg;

  // Characters the parser looks for
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_INT   = 8'h69;
  localparam logic [7:0] CH_FLOAT = 8'h66;
  localparam logic [7:0] CH_STR   = 8'h73;

  // Token kinds on the result channel
  localparam logic [2:0] TK_ADDR_BYTE = 3'd0;
  localparam logic [2:0] TK_ADDR_END  = 3'd1;
  localparam logic [2:0] TK_INT       = 3'd2;
  localparam logic [2:0] TK_FLOAT     = 3'd3;
  localparam logic [2:0] TK_STR_BYTE  = 3'd4;
  localparam logic [2:0] TK_STR_END   = 3'd5;
  localparam logic [2:0] TK_MSG_END   = 3'd6;
  localparam logic [2:0] TK_REJECTED  = 3'd7;

  localparam int unsigned LEN_W = 18;

  // One token as held in the output queue
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } tok_t;

endpackage

[hdl/osc_message_parser.sv]
// OSC message parser: byte stream in, token stream out.
//
// Input channel (in_*): one datagram byte per request, with the datagram's
// length on every byte and in_tuser marking the first byte of a datagram.
// Output channel (out_*): tokens (address bytes, argument words, string
// bytes, end markers, rejection); out_tlast flags the last token caused by
// an input byte.
// Tokens a byte causes are registered into the token queue behind any that wait.
// Throughput: one byte per cycle while each byte yields at most one token
// and the receiver keeps up; a byte yielding more tokens fills the queue faster.
// The rate is set by the single output port draining a four-entry token
// queue; the tag memory read is registered at the next tag index and never stalls.
// Stall: bytes are still taken while at most one token waits (or two with
// one leaving); beyond that in_tready drops until the queue drains.
// Reset: parser returns to searching for '/', position and counters clear,
// token queue empties. The type tag memory is not cleared; only entries
// written for the current message are ever read.
module osc_message_parser #(
  parameter int unsigned TAG_DEPTH    = 64,
  parameter int unsigned MAX_DATAGRAM = 131072
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] data_byte, [25:8] datagram_length, [31:26] zero
  input  logic        in_tuser,   // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] token_kind, [34:3] token_value, [39:35] zero
  output logic        out_tlast
);
  import oscmp_pkg::*;

  localparam int unsigned AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
  localparam int unsigned TC_W  = $clog2(TAG_DEPTH + 1);
  localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1);
  localparam int unsigned CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

  localparam logic [2:0] PH_SEEK   = 3'd0;
  localparam logic [2:0] PH_ADDR   = 3'd1;
  localparam logic [2:0] PH_COMMA  = 3'd2;
  localparam logic [2:0] PH_TAGS   = 3'd3;
  localparam logic [2:0] PH_ALIGN  = 3'd4;
  localparam logic [2:0] PH_ARGS   = 3'd5;
  localparam logic [2:0] PH_STRPAD = 3'd6;

  logic [7:0]       in_byte;
  logic [LEN_W-1:0] in_len;
  logic             in_first;
  logic             in_fire;
  logic             take;

  logic [2:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [TC_W-1:0]  tag_cnt_r, tag_cnt_nxt;
  logic [TC_W-1:0]  tag_idx_r, tag_idx_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [1:0]       wbc_r, wbc_nxt;
  logic             rej_r, rej_nxt;

  // type tag memory, registered read at the next tag index
  logic [7:0]    tag_mem [TAG_DEPTH];
  logic [7:0]    tag_rd_r;
  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  logic [AW-1:0] tag_raddr;

  // tokens produced by the current byte
  logic [2:0]  em_kind [3];
  logic [31:0] em_val  [3];
  logic [1:0]  em_n;

  logic             stop;
  logic             aligned;
  logic             do_begin;
  logic [POS_W-1:0] pos_p1;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] max_ext;

  // output queue
  tok_t       slot_r [4];
  tok_t       slot_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] base;

  assign in_byte  = in_tdata[7:0];
  assign in_len   = in_tdata[25:8];
  assign in_first = in_tuser;
  assign len_ext  = CMP_W'(in_len);
  assign max_ext  = CMP_W'(MAX_DATAGRAM);

  assign take       = out_tvalid && out_tready;
  assign in_tready  = (cnt_r <= 3'd1) || (cnt_r == 3'd2 && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {5'd0, slot_r[0].value, slot_r[0].kind};
  assign out_tlast  = slot_r[0].last;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    tag_cnt_nxt = tag_cnt_r;
    tag_idx_nxt = tag_idx_r;
    word_nxt    = word_r;
    wbc_nxt     = wbc_r;
    rej_nxt     = rej_r;
    tag_we      = 1'b0;
    tag_waddr   = tag_cnt_r[AW-1:0];
    em_n        = 2'd0;
    stop        = 1'b0;
    do_begin    = 1'b0;
    pos_p1      = pos_r + POS_W'(1);
    aligned     = (pos_p1[1:0] == 2'd0);
    for (int k = 0; k < 3; k++) begin
      em_kind[k] = TK_ADDR_BYTE;
      em_val[k]  = 32'd0;
    end

    if (in_fire) begin
      if (in_first) begin
        pos_nxt     = '0;
        phase_nxt   = PH_SEEK;
        tag_cnt_nxt = '0;
        tag_idx_nxt = '0;
        word_nxt    = 32'd0;
        wbc_nxt     = 2'd0;
        rej_nxt     = (in_len[1:0] != 2'd0) || (len_ext > max_ext);
        if (rej_nxt) begin
          em_kind[0] = TK_REJECTED;
          em_n       = 2'd1;
          stop       = 1'b1;
        end
      end else if (rej_r) begin
        stop = 1'b1;
      end

      if (!stop && (CMP_W'(pos_nxt) >= len_ext || CMP_W'(pos_nxt) >= max_ext)) begin
        stop = 1'b1;
      end

      if (!stop) begin
        pos_p1  = pos_nxt + POS_W'(1);
        aligned = (pos_p1[1:0] == 2'd0);
        pos_nxt = pos_p1;
        unique case (phase_nxt)
          PH_SEEK: begin
            if (in_byte == CH_SLASH) begin
              tag_cnt_nxt = '0;
              tag_idx_nxt = '0;
              em_kind[em_n] = TK_ADDR_BYTE;
              em_val[em_n]  = 32'(in_byte);
              em_n          = em_n + 2'd1;
              phase_nxt     = PH_ADDR;
            end
          end
          PH_ADDR: begin
            if (in_byte == 8'd0) begin
              em_kind[em_n] = TK_ADDR_END;
              em_n          = em_n + 2'd1;
              phase_nxt     = PH_COMMA;
            end else begin
              em_kind[em_n] = TK_ADDR_BYTE;
              em_val[em_n]  = 32'(in_byte);
              em_n          = em_n + 2'd1;
            end
          end
          PH_COMMA: begin
            if (in_byte == CH_COMMA) phase_nxt = PH_TAGS;
          end
          PH_TAGS: begin
            if (in_byte == 8'd0) begin
              tag_idx_nxt = '0;
              if (aligned) do_begin = 1'b1;
              else         phase_nxt = PH_ALIGN;
            end else if (tag_cnt_nxt < TC_W'(TAG_DEPTH)) begin
              tag_we      = 1'b1;
              tag_cnt_nxt = tag_cnt_nxt + TC_W'(1);
            end
          end
          PH_ALIGN: begin
            if (aligned) do_begin = 1'b1;
          end
          PH_ARGS: begin
            if (tag_rd_r == CH_STR) begin
              if (in_byte != 8'd0) begin
                em_kind[em_n] = TK_STR_BYTE;
                em_val[em_n]  = 32'(in_byte);
                em_n          = em_n + 2'd1;
                wbc_nxt       = 2'd1;
              end else begin
                em_kind[em_n] = TK_STR_END;
                em_n          = em_n + 2'd1;
                wbc_nxt       = 2'd0;
                if (aligned) begin
                  tag_idx_nxt = tag_idx_nxt + TC_W'(1);
                  do_begin    = 1'b1;
                end else begin
                  phase_nxt = PH_STRPAD;
                end
              end
            end else begin
              word_nxt = {word_nxt[23:0], in_byte};
              if (wbc_nxt == 2'd3) begin
                if (tag_rd_r == CH_INT) begin
                  em_kind[em_n] = TK_INT;
                  em_val[em_n]  = word_nxt;
                  em_n          = em_n + 2'd1;
                end else if (tag_rd_r == CH_FLOAT) begin
                  em_kind[em_n] = TK_FLOAT;
                  em_val[em_n]  = word_nxt;
                  em_n          = em_n + 2'd1;
                end
                tag_idx_nxt = tag_idx_nxt + TC_W'(1);
                do_begin    = 1'b1;
              end else begin
                wbc_nxt = wbc_nxt + 2'd1;
              end
            end
          end
          PH_STRPAD: begin
            if (aligned) begin
              tag_idx_nxt = tag_idx_nxt + TC_W'(1);
              do_begin    = 1'b1;
            end
          end
          default: phase_nxt = PH_SEEK;
        endcase

        if (do_begin) begin
          word_nxt = 32'd0;
          wbc_nxt  = 2'd0;
          if (tag_idx_nxt >= tag_cnt_nxt) begin
            em_kind[em_n] = TK_MSG_END;
            em_n          = em_n + 2'd1;
            phase_nxt     = PH_SEEK;
          end else begin
            phase_nxt = PH_ARGS;
          end
        end

        // datagram end closes the open message; a partial word is dropped
        if (CMP_W'(pos_p1) == len_ext && phase_nxt != PH_SEEK) begin
          if (phase_nxt == PH_ADDR) begin
            em_kind[em_n] = TK_ADDR_END;
            em_n          = em_n + 2'd1;
          end else if (phase_nxt == PH_ARGS && tag_rd_r == CH_STR && wbc_nxt != 2'd0) begin
            em_kind[em_n] = TK_STR_END;
            em_n          = em_n + 2'd1;
          end
          em_kind[em_n] = TK_MSG_END;
          em_n          = em_n + 2'd1;
          phase_nxt     = PH_SEEK;
          word_nxt      = 32'd0;
          wbc_nxt       = 2'd0;
        end
      end
    end
  end

  // the last tag write lands before the tag is needed,
  // so the registered read never misses a fresh entry
  assign tag_raddr = (tag_idx_nxt < TC_W'(TAG_DEPTH)) ? tag_idx_nxt[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= in_byte;
    tag_rd_r <= tag_mem[tag_raddr];
  end

  // queue: shift out on take, append this byte's tokens behind what stays
  always_comb begin
    base = cnt_r - {2'd0, take};
    for (int i = 0; i < 4; i++) begin
      if (take && i < 3) slot_nxt[i] = slot_r[i+1];
      else               slot_nxt[i] = slot_r[i];
      for (int k = 0; k < 3; k++) begin
        if (in_fire && 2'(k) < em_n && (base + 3'(k)) == 3'(i)) begin
          slot_nxt[i].kind  = em_kind[k];
          slot_nxt[i].value = em_val[k];
          slot_nxt[i].last  = (2'(k) == em_n - 2'd1);
        end
      end
    end
    cnt_nxt = base + (in_fire ? {1'b0, em_n} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SEEK;
      pos_r     <= '0;
      tag_cnt_r <= '0;
      tag_idx_r <= '0;
      word_r    <= 32'd0;
      wbc_r     <= 2'd0;
      rej_r     <= 1'b0;
      cnt_r     <= 3'd0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      tag_cnt_r <= tag_cnt_nxt;
      tag_idx_r <= tag_idx_nxt;
      word_r    <= word_nxt;
      wbc_r     <= wbc_nxt;
      rej_r     <= rej_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) slot_r[i] <= slot_nxt[i];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("token queue overfilled");

  a_args_tag_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ARGS) |-> (tag_idx_r < tag_cnt_r))
    else $error("argument parse without a stored tag");

  a_tag_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tag_cnt_r <= TC_W'(TAG_DEPTH))
    else $error("tag count beyond memory depth");

  a_queue_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd0) |-> slot_r[2'(cnt_r - 3'd1)].last)
    else $error("queue tail is not the last token of a byte");

  a_reject_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && rej_r && !in_first && !take) |=> (cnt_r == $past(cnt_r)))
    else $error("token produced inside a rejected datagram");

endmodule
